[sv/qte_pkg.sv]
// ----------------------------------------------------------------------------
// qte_pkg
// Shared types, constants and the arctangent table for quaternion_to_euler.
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int QTE_STAGES    = 16;
  localparam int QTE_TAB_LEN   = 24;
  localparam int QTE_PW        = 34;   // numerator/denominator width
  localparam int QTE_SW        = 32;   // clamped asin argument
  localparam int QTE_SQW       = 61;   // s squared, Q.60
  localparam int QTE_RW        = 62;   // square root working register
  localparam int QTE_SQRT_STEPS = 31;
  localparam int QTE_XW        = 36;   // CORDIC x/y width
  localparam int QTE_ZW        = 34;   // CORDIC angle accumulator, Q2.30
  localparam int QTE_OW        = 17;   // rounded angle before clamping

  localparam logic signed [QTE_ZW-1:0] QTE_HALF_PI = 34'sd1686629713;
  localparam logic signed [QTE_PW-1:0] QTE_ONE_Q30 = 34'sd1073741824;
  localparam int QTE_ANG_MAX   = 25736;
  localparam int QTE_PITCH_MAX = 12868;

  typedef struct packed {
    logic signed [QTE_PW-1:0] yn;
    logic signed [QTE_PW-1:0] yd;
    logic signed [QTE_PW-1:0] rn;
    logic signed [QTE_PW-1:0] rd;
    logic signed [QTE_SW-1:0] s;
  } qte_side_t;

  // atan(2^-i), Q2.30
  function automatic logic signed [QTE_ZW-1:0] qte_atan(input int i);
    logic signed [QTE_ZW-1:0] r;
    case (i)
      0:  r = 34'sh03243F6A8;
      1:  r = 34'sh01DAC6705;
      2:  r = 34'sh00FADBAFC;
      3:  r = 34'sh007F56EA6;
      4:  r = 34'sh003FEAB76;
      5:  r = 34'sh001FFD55B;
      6:  r = 34'sh000FFFAAA;
      7:  r = 34'sh0007FFF55;
      8:  r = 34'sh0003FFFEA;
      9:  r = 34'sh0001FFFFD;
      10: r = 34'sh0000FFFFF;
      11: r = 34'sh00007FFFF;
      12: r = 34'sh00003FFFF;
      13: r = 34'sh00001FFFF;
      14: r = 34'sh00000FFFF;
      15: r = 34'sh000007FFF;
      16: r = 34'sh000003FFF;
      17: r = 34'sh000001FFF;
      18: r = 34'sh000000FFF;
      19: r = 34'sh0000007FF;
      20: r = 34'sh0000003FF;
      21: r = 34'sh0000001FF;
      22: r = 34'sh0000000FF;
      23: r = 34'sh00000007F;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[sv/qte_front.sv]
// ----------------------------------------------------------------------------
// qte_front
// Quaternion products, angle numerators and denominators, asin argument
// clamp and its square. Four register stages.
// ----------------------------------------------------------------------------
module qte_front import qte_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic signed [15:0]       quat_w_i,
  input  logic signed [15:0]       quat_x_i,
  input  logic signed [15:0]       quat_y_i,
  input  logic signed [15:0]       quat_z_i,
  output logic                     valid_o,
  output qte_side_t                side_o,
  output logic        [QTE_SQW-1:0] sq_o
);

  logic signed [31:0] xy_q, wz_q, yy_q, zz_q, wx_q, yz_q, xx_q, wy_q, zx_q;
  logic signed [QTE_PW-1:0] yn_q, yd_q, rn_q, rd_q, sr_q;
  logic signed [QTE_SW-1:0] sc_d;
  qte_side_t side3_q, side4_q;
  logic [QTE_SQW-1:0] sq_q;
  logic signed [2*QTE_SW-1:0] sq_d;
  logic [3:0] v_q;

  always_comb begin
    if (sr_q > QTE_ONE_Q30) begin
      sc_d = QTE_SW'(QTE_ONE_Q30);
    end else if (sr_q < -QTE_ONE_Q30) begin
      sc_d = QTE_SW'(-QTE_ONE_Q30);
    end else begin
      sc_d = QTE_SW'(sr_q);
    end
    sq_d = side3_q.s * side3_q.s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xy_q <= quat_x_i * quat_y_i;
      wz_q <= quat_w_i * quat_z_i;
      yy_q <= quat_y_i * quat_y_i;
      zz_q <= quat_z_i * quat_z_i;
      wx_q <= quat_w_i * quat_x_i;
      yz_q <= quat_y_i * quat_z_i;
      xx_q <= quat_x_i * quat_x_i;
      wy_q <= quat_w_i * quat_y_i;
      zx_q <= quat_z_i * quat_x_i;

      yn_q <= (QTE_PW'(xy_q) + QTE_PW'(wz_q)) <<< 1;
      yd_q <= QTE_ONE_Q30 - ((QTE_PW'(yy_q) + QTE_PW'(zz_q)) <<< 1);
      rn_q <= (QTE_PW'(wx_q) + QTE_PW'(yz_q)) <<< 1;
      rd_q <= QTE_ONE_Q30 - ((QTE_PW'(xx_q) + QTE_PW'(yy_q)) <<< 1);
      sr_q <= (QTE_PW'(wy_q) - QTE_PW'(zx_q)) <<< 1;

      side3_q.yn <= yn_q;
      side3_q.yd <= yd_q;
      side3_q.rn <= rn_q;
      side3_q.rd <= rd_q;
      side3_q.s  <= sc_d;

      side4_q <= side3_q;
      sq_q    <= QTE_SQW'(sq_d);
    end
  end

  assign valid_o = v_q[3];
  assign side_o  = side4_q;
  assign sq_o    = sq_q;

endmodule

[sv/qte_isqrt.sv]
// ----------------------------------------------------------------------------
// qte_isqrt
// Pipelined integer square root of 2^60 - s^2, one result bit per stage.
// Carries the angle operands alongside.
// ----------------------------------------------------------------------------
module qte_isqrt import qte_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  qte_side_t                 side_i,
  input  logic        [QTE_SQW-1:0] sq_i,
  output logic                      valid_o,
  output qte_side_t                 side_o,
  output logic        [QTE_SW-1:0]  root_o
);

  localparam int N = QTE_SQRT_STEPS;

  logic [QTE_RW-1:0] rem_q [0:N];
  logic [QTE_RW-1:0] res_q [0:N];
  qte_side_t         side_q [0:N];
  logic [N:0]        v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[N-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= (QTE_RW'(1) << 60) - QTE_RW'(sq_i);
      res_q[0]  <= '0;
      side_q[0] <= side_i;
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_step
    localparam logic [QTE_RW-1:0] Bit = QTE_RW'(1) << (60 - 2 * j);
    logic [QTE_RW-1:0] trial;
    assign trial = res_q[j] + Bit;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[j+1] <= side_q[j];
        if (rem_q[j] >= trial) begin
          rem_q[j+1] <= rem_q[j] - trial;
          res_q[j+1] <= (res_q[j] >> 1) + Bit;
        end else begin
          rem_q[j+1] <= rem_q[j];
          res_q[j+1] <= res_q[j] >> 1;
        end
      end
    end
  end

  assign valid_o = v_q[N];
  assign side_o  = side_q[N];
  assign root_o  = res_q[N][QTE_SW-1:0];

endmodule

[sv/qte_cordic.sv]
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined vectoring CORDIC atan2 with quadrant pre-rotation, rounding to
// Q3.13 and symmetric clamping.
// ----------------------------------------------------------------------------
module qte_cordic import qte_pkg::*; #(
  parameter int STAGES = QTE_STAGES,
  parameter int LIM    = QTE_ANG_MAX,
  parameter int OUT_W  = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic signed [QTE_XW-1:0] x_i,
  input  logic signed [QTE_XW-1:0] y_i,
  output logic                     valid_o,
  output logic signed [OUT_W-1:0]  angle_o
);

  localparam int NS = (STAGES < QTE_TAB_LEN) ? STAGES : QTE_TAB_LEN;
  localparam logic signed [QTE_OW-1:0] LimP = QTE_OW'(LIM);
  localparam logic signed [QTE_OW-1:0] LimN = -QTE_OW'(LIM);

  logic signed [QTE_XW-1:0] x_q [0:NS];
  logic signed [QTE_XW-1:0] y_q [0:NS];
  logic signed [QTE_ZW-1:0] z_q [0:NS];
  logic        [NS:0]       zero_q;
  logic        [NS+1:0]     v_q;
  logic signed [QTE_ZW-1:0] zr;
  logic signed [QTE_OW-1:0] rnd;
  logic signed [OUT_W-1:0]  angle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NS:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      if (x_i[QTE_XW-1] && !y_i[QTE_XW-1]) begin
        x_q[0] <= y_i;
        y_q[0] <= -x_i;
        z_q[0] <= QTE_HALF_PI;
      end else if (x_i[QTE_XW-1]) begin
        x_q[0] <= -y_i;
        y_q[0] <= x_i;
        z_q[0] <= -QTE_HALF_PI;
      end else begin
        x_q[0] <= x_i;
        y_q[0] <= y_i;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_iter
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (!y_q[i][QTE_XW-1]) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + qte_atan(i);
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - qte_atan(i);
        end
      end
    end
  end

  always_comb begin
    zr  = zero_q[NS] ? '0 : z_q[NS];
    rnd = QTE_OW'((zr + QTE_ZW'(65536)) >>> 17);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (rnd > LimP) begin
        angle_q <= OUT_W'(LimP);
      end else if (rnd < LimN) begin
        angle_q <= OUT_W'(LimN);
      end else begin
        angle_q <= OUT_W'(rnd);
      end
    end
  end

  assign valid_o = v_q[NS+1];
  assign angle_o = angle_q;

endmodule

[sv/quaternion_to_euler.sv]
// ----------------------------------------------------------------------------
// quaternion_to_euler
// ZYX Euler angles (yaw, pitch, roll) of a Q1.15 quaternion, Q3.13 radians.
// ----------------------------------------------------------------------------
// Takes one quaternion per clock and returns yaw, pitch and roll after the
// register stages of products and clamping, the bit-per-stage square root
// that forms cos(pitch), and the three parallel CORDIC pipelines of
// CORDIC_STAGES iterations (capped at 24). Back-pressure on the output
// stalls the whole pipeline; while it is not stalled a new transaction is
// accepted every cycle. Pitch saturates at +-pi/2 when the asin argument
// exceeds one.
module quaternion_to_euler import qte_pkg::*; #(
  parameter int CORDIC_STAGES = QTE_STAGES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // quat_w, quat_x, quat_y, quat_z
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o    // yaw_angle, pitch_angle, roll_angle, pad
);

  logic              en;
  logic              fr_valid, sq_valid, yaw_valid, pitch_valid, roll_valid;
  qte_side_t         fr_side, sq_side;
  logic [QTE_SQW-1:0] fr_sq;
  logic [QTE_SW-1:0]  root;
  logic signed [15:0] yaw, roll;
  logic signed [14:0] pitch;

  assign en              = !pitch_valid || m_axis_tready_i;
  assign s_axis_tready_o = en;

  qte_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_axis_tvalid_i),
    .quat_w_i (s_axis_tdata_i[15:0]),
    .quat_x_i (s_axis_tdata_i[31:16]),
    .quat_y_i (s_axis_tdata_i[47:32]),
    .quat_z_i (s_axis_tdata_i[63:48]),
    .valid_o  (fr_valid),
    .side_o   (fr_side),
    .sq_o     (fr_sq)
  );

  qte_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .side_i  (fr_side),
    .sq_i    (fr_sq),
    .valid_o (sq_valid),
    .side_o  (sq_side),
    .root_o  (root)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES), .LIM(QTE_ANG_MAX), .OUT_W(16)) u_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .x_i     (QTE_XW'(sq_side.yd)),
    .y_i     (QTE_XW'(sq_side.yn)),
    .valid_o (yaw_valid),
    .angle_o (yaw)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES), .LIM(QTE_PITCH_MAX), .OUT_W(15)) u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .x_i     (QTE_XW'({1'b0, root})),
    .y_i     (QTE_XW'(sq_side.s)),
    .valid_o (pitch_valid),
    .angle_o (pitch)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES), .LIM(QTE_ANG_MAX), .OUT_W(16)) u_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .x_i     (QTE_XW'(sq_side.rd)),
    .y_i     (QTE_XW'(sq_side.rn)),
    .valid_o (roll_valid),
    .angle_o (roll)
  );

  assign m_axis_tvalid_o = pitch_valid;
  assign m_axis_tdata_o  = {1'b0, roll, pitch, yaw};

`ifndef SYNTHESIS
  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (yaw_valid == pitch_valid) && (roll_valid == pitch_valid))
    else $error("angle lanes out of step");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pitch_valid |-> (pitch <= 15'sd12868) && (pitch >= -15'sd12868))
    else $error("pitch out of range");

  a_yaw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    yaw_valid |-> (yaw <= 16'sd25736) && (yaw >= -16'sd25736))
    else $error("yaw out of range");

  a_roll_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    roll_valid |-> (roll <= 16'sd25736) && (roll >= -16'sd25736))
    else $error("roll out of range");
`endif

endmodule
